// File: rtl/core/rdrc_pkg.sv
package rdrc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int SQ_W     = 32;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_SLOPE     = 2'd1;
  localparam logic [IDX_W-1:0] REG_ATTACK    = 2'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 2'd3;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -16'sd24576;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic load;     // capture the input item and start the ring read
    logic ring_upd; // update the running sum and write the ring
    logic log_init; // mean, exponent and mantissa for the log
    logic log_step; // one fraction bit of the log
    logic smooth;   // level and previous smoothed level
    logic smooth2;  // smoothing product
    logic gain;     // new smoothed level
    logic exp_step; // gain product, gain and octave count
    logic scale;    // one factor multiply
    logic finish;   // sample times factor, then round, shift and saturate
  } rdrc_cmd_t;

  typedef struct packed {
    logic clear_busy;
  } rdrc_stat_t;

  // 2^(-2^-k) for k = 1..8, Q16
  function automatic logic [15:0] exp_entry(input logic [2:0] k);
    logic [15:0] v;
    unique case (k)
      3'd0: v = 16'd46341;
      3'd1: v = 16'd55109;
      3'd2: v = 16'd60097;
      3'd3: v = 16'd62757;
      3'd4: v = 16'd64132;
      3'd5: v = 16'd64830;
      3'd6: v = 16'd65182;
      default: v = 16'd65359;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/rdrc_datapath.sv
module rdrc_datapath import rdrc_pkg::*; #(
  parameter int WINDOW_LEN   = 256,
  parameter int NUM_CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rdrc_cmd_t                  cmd,
  input  logic [2:0]                 step,
  output rdrc_stat_t                 stat,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_channel,
  input  logic                       in_last,
  input  logic signed [15:0]         threshold_db,
  input  logic [15:0]                slope,
  input  logic [15:0]                attack_coef,
  input  logic [15:0]                release_coef,
  output logic [39:0]                out_data,
  output logic                       out_last
);

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH  = NUM_CHANNELS * WINDOW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = SQ_W + POS_W + 1;
  localparam int CLR_W  = ADDR_W + 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

  logic [SQ_W-1:0]  ring [DEPTH];
  logic [SQ_W-1:0]  ring_q;
  logic [SUM_W-1:0] square_sum [NUM_CHANNELS];
  logic [POS_W-1:0] ring_pos [NUM_CHANNELS];
  logic signed [LEVEL_W-1:0] level_smoothed [NUM_CHANNELS];

  logic signed [SAMPLE_W-1:0] s;
  logic                       ch_raw;
  logic                       last;
  logic                       used;
  logic [CH_W-1:0]            ch;
  logic [ADDR_W-1:0]          slot;
  logic [ADDR_W-1:0]          slot_in;
  logic [SQ_W-1:0]            sq;
  logic [SUM_W-1:0]           sum_new;
  logic [SQ_W-1:0]            mean;
  logic [SQ_W-1:0]            mean_c;
  logic [4:0]                 e;
  logic [4:0]                 e_c;
  logic [16:0]                m;
  logic [7:0]                 frac;
  logic signed [LEVEL_W-1:0]  level;
  logic signed [LEVEL_W-1:0]  old;
  logic signed [LEVEL_W-1:0]  nw;
  logic signed [LEVEL_W-1:0]  nw_c;
  logic signed [33:0]         prod;
  logic signed [15:0]         gain;
  logic [12:0]                oct;
  logic [16:0]                f;
  logic [33:0]                mag;
  logic signed [SAMPLE_W-1:0] y;
  logic [CLR_W-1:0]           clr_cnt;
  logic                       clr_busy;

  assign stat.clear_busy = clr_busy;

  // After reset the ring is swept to zero one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clr_busy <= 1'b1;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(DEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  // The slot of a new item is read at the edge that accepts it.
  assign slot_in = ADDR_W'(32'(in_channel) * WINDOW_LEN + 32'(ring_pos[CH_W'(in_channel)]));

  always_ff @(posedge clk) begin
    if (clr_busy) ring[clr_cnt[ADDR_W-1:0]] <= '0;
    else if (cmd.ring_upd && used) ring[slot] <= sq;
    ring_q <= ring[cmd.load ? slot_in : slot];
  end

  // Leading one of the mean.
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) if (v[i]) p = 5'(i);
    return p;
  endfunction

  logic [31:0] m_sq;
  logic [31:0] msh;
  logic signed [17:0] dlev;
  logic [15:0] coef;
  logic signed [LEVEL_W+1:0] lvl3;
  logic signed [16:0] thr_diff;
  logic [16:0] neg_gain;
  logic [33:0] f_prod;
  logic [5:0] sh;
  logic [33:0] rnd;
  logic [33:0] mag_r;
  logic [16:0] smag;

  always_comb begin
    sq        = SQ_W'(32'(s) * 32'(s));
    sum_new   = square_sum[ch] - SUM_W'(ring_q) + SUM_W'(sq);
    // The window length is a power of two, so the mean is a shift.
    mean_c    = SQ_W'(square_sum[ch] >> POS_W);
    e_c       = msb_pos(mean_c);
    m_sq      = 32'((34'(m) * 34'(m)) >> 15);
    msh       = (e_c >= 5'd15) ? (mean_c >> (e_c - 5'd15)) : (mean_c << (5'd15 - e_c));
    lvl3      = 18'sd3 * (18'($signed({10'd0, e, frac})) - 18'sd7680);
    dlev      = 18'(old) - 18'(level);
    coef      = (level > old) ? attack_coef : release_coef;
    nw_c      = 16'(18'(level) + 18'(prod >>> 16));
    thr_diff  = 17'(threshold_db) - 17'(nw);
    neg_gain  = 17'(-18'(gain));
    f_prod    = 34'(f) * 34'(exp_entry(step)) + 34'd32768;
    sh        = 6'd16 + 6'(oct[12:8]);
    rnd       = 34'd1 << (sh - 6'd1);
    mag_r     = (mag + rnd) >> sh;
    smag      = (mag_r > 34'd32768) ? 17'd32768 : mag_r[16:0];
    if (s < 0) y = (smag >= 17'd32768) ? -16'sd32768 : -16'(smag);
    else       y = (smag >= 17'd32767) ? 16'sd32767 : 16'(smag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        square_sum[i]     <= '0;
        ring_pos[i]       <= '0;
        level_smoothed[i] <= '0;
      end
    end else begin
      if (cmd.ring_upd && used) begin
        square_sum[ch] <= sum_new;
        ring_pos[ch]   <= (ring_pos[ch] == POS_LAST) ? '0 : ring_pos[ch] + 1'b1;
      end
      if (cmd.gain && used) level_smoothed[ch] <= nw_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s      <= in_sample;
      ch_raw <= in_channel;
      last   <= in_last;
      used   <= (32'(in_channel) < NUM_CHANNELS);
      ch     <= CH_W'(in_channel);
      slot   <= slot_in;
    end
    if (cmd.log_init) begin
      mean <= mean_c;
      e    <= e_c;
      m    <= 17'(msh);
      frac <= '0;
    end
    if (cmd.log_step) begin
      m                <= m_sq[16] ? 17'(m_sq >> 1) : 17'(m_sq);
      frac[3'd7 - step] <= m_sq[16];
    end
    if (cmd.smooth) begin
      level <= (mean == '0) ? LEVEL_FLOOR : 16'(lvl3);
      old   <= level_smoothed[ch];
    end
    if (cmd.smooth2) begin
      prod <= 34'($signed({1'b0, coef})) * 34'(dlev) + 34'sd32768;
    end
    if (cmd.gain) begin
      nw <= nw_c;
    end
    if (cmd.exp_step) begin
      if (step == 3'd0) begin
        prod <= 34'($signed({1'b0, slope})) * 34'(thr_diff) + 34'sd2048;
      end else if (step == 3'd1) begin
        if (!(nw > threshold_db) || !used) gain <= '0;
        else if ((prod >>> 12) < -34'sd32768) gain <= -16'sd32768;
        else if ((prod >>> 12) > 34'sd0) gain <= '0;
        else gain <= 16'(prod >>> 12);
      end else if (step == 3'd2) begin
        oct <= 13'((32'(neg_gain) + 32'd3) * 32'd43691 >> 18);
        f   <= 17'd65536;
      end
    end
    if (cmd.scale) begin
      if (oct[3'd7 - step]) f <= 17'(f_prod >> 16);
    end
    if (cmd.finish && step == 3'd0) begin
      mag <= 34'(s < 0 ? -17'(s) : 17'(s)) * 34'(f);
    end
    if (cmd.finish && step == 3'd1) begin
      out_data <= {7'd0, (used ? gain : 16'sd0), ch_raw,
                   (!used ? s : ((sh >= 6'd60) ? 16'sd0 : y))};
      out_last <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_gain_nonpos: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && step == 3'd1 && used |=> $signed(out_data[32:17]) <= 0)
    else $error("gain positive");
  a_no_load_clr: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !cmd.load) else $error("item during clear");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_pos[0] <= POS_LAST) else $error("ring position range");
`endif

endmodule

// File: rtl/core/rdrc_ctrl.sv
module rdrc_ctrl import rdrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rdrc_stat_t stat,
  output rdrc_cmd_t  cmd,
  output logic [2:0] step
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RING, S_LOGI, S_LOG, S_SM, S_SM2, S_GN, S_GAIN, S_EXP, S_FIN, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    cmd = '0;
    cmd.load     = in_valid && in_ready;
    cmd.ring_upd = (state == S_RING);
    cmd.log_init = (state == S_LOGI);
    cmd.log_step = (state == S_LOG);
    cmd.smooth   = (state == S_SM);
    cmd.smooth2  = (state == S_SM2);
    cmd.gain     = (state == S_GN);
    cmd.exp_step = (state == S_GAIN);
    cmd.scale    = (state == S_EXP);
    cmd.finish   = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (!stat.clear_busy) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_RING;
        S_RING:  state <= S_LOGI;
        S_LOGI:  begin state <= S_LOG; step <= '0; end
        S_LOG:   begin
          step <= step + 1'b1;
          if (step == 3'd7) begin state <= S_SM; step <= '0; end
        end
        S_SM:    state <= S_SM2;
        S_SM2:   state <= S_GN;
        S_GN:    begin state <= S_GAIN; step <= '0; end
        S_GAIN:  begin
          step <= step + 1'b1;
          if (step == 3'd2) begin state <= S_EXP; step <= '0; end
        end
        S_EXP:   begin
          step <= step + 1'b1;
          if (step == 3'd7) begin state <= S_FIN; step <= '0; end
        end
        S_FIN:   begin
          step <= step + 1'b1;
          if (step == 3'd1) begin state <= S_OUT; out_valid <= 1'b1; step <= '0; end
        end
        S_OUT:   if (!out_valid || out_ready) state <= (in_valid ? S_RING : S_IDLE);
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("output outside result state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_LOG |-> !in_ready) else $error("accept while busy");
  a_ch_seen: assert property (@(posedge clk) disable iff (rst)
    state == S_SM |=> state == S_SM2) else $error("sequence broken");
`endif

endmodule

// File: rtl/core/rms_dynamic_range_compressor.sv
// RMS compressor for interleaved Q1.15 audio. Each item passes in turn through a
// ring update, a log set-up step, eight log fraction iterations, two smoothing
// steps, a level update, three gain steps, eight exponent-factor multiplies and
// two scaling steps, all set by the sequencer. The next item is taken in the
// cycle the result is handed over, so items do not overlap, and a stalled output
// holds the input off. After reset the square ring is cleared, one entry a cycle,
// before the first item is taken. WINDOW_LEN must be a power of two.
// Configuration should be written only while no item is in the block.
module rms_dynamic_range_compressor import rdrc_pkg::*; #(
  parameter int WINDOW_LEN   = 256,
  parameter int NUM_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // sample_in[15:0], channel[16], zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // sample_out[15:0], channel_out[16], gain_db[32:17]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] threshold_db;
  logic [15:0] slope, attack_coef, release_coef;
  rdrc_cmd_t  cmd;
  rdrc_stat_t stat;
  logic [2:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db <= -16'sd4608;
      slope        <= 16'd3072;
      attack_coef  <= 16'd65506;
      release_coef <= 16'd65528;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold_db <= cfg_data;
          REG_SLOPE:     slope        <= cfg_data;
          REG_ATTACK:    attack_coef  <= cfg_data;
          REG_RELEASE:   release_coef <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  rdrc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat, .cmd, .step
  );

  rdrc_datapath #(.WINDOW_LEN(WINDOW_LEN), .NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk, .rst, .cmd, .step, .stat,
    .in_sample(s_axis_tdata[15:0]), .in_channel(s_axis_tdata[16]), .in_last(s_axis_tlast),
    .threshold_db, .slope, .attack_coef, .release_coef,
    .out_data(m_axis_tdata), .out_last(m_axis_tlast)
  );

endmodule
